/* hw/rtl/tsws_pkg.sv */
// Shared types and constants of the time slot window scheduler.
// Holds the word structs, the controller command and status structs and the state enum.
// No dependencies.
package tsws_pkg;

	localparam int MAX_WINDOWS = 4;
	localparam int ENTRY_COUNT = 4;
	localparam int WIN_IDX_W   = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int WIU_W       = 3;
	localparam int TIME_W      = 32;
	localparam int RATE_W      = 16;
	localparam int DIV_W       = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_W);

	// Register indexes of the configuration port; lower indexes select window entries.
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_ENTRY_0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOWS_IN_USE = 3'd4;

	localparam logic [CFG_DATA_W-1:0] ENTRY_RESET [ENTRY_COUNT] = '{
		{16'd2600, 32'd180000},
		{16'd1300, 32'd180000},
		{16'd650,  32'd180000},
		{16'd325,  32'd180000}
	};
	localparam logic [WIU_W-1:0] WIU_RESET = 3'd4;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] offset_ms;
	} in_item_t;

	typedef struct packed {
		logic                 window_changed;
		logic [WIN_IDX_W-1:0] window_index;
		logic [RATE_W-1:0]    bitrate_kbps;
		logic [TIME_W-1:0]    cycles_elapsed;
		logic [TIME_W-1:0]    time_in_window_ms;
		logic [TIME_W-1:0]    time_to_switch_ms;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_SETUP,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_ALIGN,
		ST_LOCATE,
		ST_COMMIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		DIV_NOW,
		DIV_OFFSET,
		DIV_SINCE
	} div_sel_t;

	typedef struct packed {
		logic                 latch;
		logic                 prefix_step;
		logic                 div_start;
		div_sel_t             div_sel;
		logic                 align;
		logic                 locate_step;
		logic                 commit;
		logic                 finish;
		logic                 load_out;
		logic [WIN_IDX_W-1:0] step_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mode;
		logic active;
		logic div_busy;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

/* hw/rtl/time_slot_window_scheduler.sv */
// Time slot window scheduler: a repeating schedule of up to four windows, each a bitrate
// and a duration. An update word places a time in the cycle; a realign word sets the cycle
// start from a time and a phase offset. Every word in gives one result word out. Each word
// first walks the window durations; with an active schedule the 32-step serial divider then
// runs once per update and three times per realign, and a second walk locates the window,
// and the result then waits for a free output slot. The result sits in an
// output register, so the next word is taken while a finished result still waits.
// Depends on tsws_pkg, tsws_ctrl and tsws_datapath.
module time_slot_window_scheduler import tsws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	tsws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tsws_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	// An accepted word keeps the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after an accepted word");

	// A divide is never launched while one is still running.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

	// A result is loaded only into a free output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result loaded over a waiting word");

	// A new result word appears only from a load command.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("output valid rose without a load");

endmodule

/* hw/rtl/tsws_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Uses tsws_pkg for widths.
module tsws_div import tsws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              busy,
	output logic              done,
	output logic [DIV_W-1:0]  quotient,
	output logic [DIV_W-1:0]  remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// The dividend shifts out at the top while quotient bits enter at the bottom.
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hw/rtl/tsws_datapath.sv */
// Datapath of the scheduler: configuration registers, schedule state, duration walks,
// the serial divider and the output word register. Uses tsws_pkg and tsws_div.
module tsws_datapath import tsws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  in_item_t               in_data,
	input  logic                   out_stall,
	output logic                   out_valid,
	output out_item_t              out_data,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             sts
);

	logic [CFG_DATA_W-1:0] entry_q [ENTRY_COUNT];
	logic [WIU_W-1:0]      wiu_q;
	in_item_t              item_q;
	logic [TIME_W-1:0]     acc_q;
	logic [TIME_W-1:0]     walk_q;
	logic                  found_q;
	logic [WIN_IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0]     lo_q;
	logic [TIME_W-1:0]     hi_q;
	logic [TIME_W-1:0]     base_q;
	logic [TIME_W-1:0]     start_q;
	logic [WIN_IDX_W-1:0]  aw_q;
	logic [TIME_W-1:0]     cc_q;
	logic                  changed_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic [WIU_W-1:0]      n_used;
	logic                  active;
	logic [WIN_IDX_W-1:0]  rd_idx;
	logic [CFG_DATA_W-1:0] rd_entry;
	logic [TIME_W-1:0]     rd_dur;
	logic [RATE_W-1:0]     rd_rate;
	logic                  step_in_use;
	logic                  first_step;
	logic [TIME_W-1:0]     t_len;
	logic [TIME_W-1:0]     since;
	logic [DIV_W-1:0]      div_dividend;
	logic [DIV_W-1:0]      div_divisor;
	logic                  div_busy;
	logic                  div_done;
	logic [DIV_W-1:0]      div_quo;
	logic [DIV_W-1:0]      div_rem;
	logic [TIME_W-1:0]     start_sum;
	logic [TIME_W-1:0]     start_fix;
	logic [TIME_W-1:0]     acc_base;
	logic [TIME_W-1:0]     walk_base;
	logic [TIME_W-1:0]     walk_nxt;
	logic                  found_cur;

	assign n_used      = (wiu_q > WIU_W'(MAX_WINDOWS)) ? WIU_W'(MAX_WINDOWS) : wiu_q;
	assign active      = (n_used != '0) && (acc_q != '0);
	assign rd_idx      = cmd.finish ? aw_q : cmd.step_idx;
	assign rd_entry    = entry_q[rd_idx];
	assign rd_dur      = rd_entry[TIME_W-1:0];
	assign rd_rate     = rd_entry[CFG_DATA_W-1:TIME_W];
	assign step_in_use = {1'b0, cmd.step_idx} < n_used;
	assign first_step  = cmd.step_idx == '0;
	assign t_len       = (acc_q == '0) ? TIME_W'(1) : acc_q;
	assign since       = item_q.now_ms - start_q;

	always_comb begin
		case (cmd.div_sel)
			DIV_NOW: begin
				div_dividend = item_q.now_ms;
				div_divisor  = t_len;
			end
			DIV_OFFSET: begin
				div_dividend = item_q.offset_ms;
				div_divisor  = t_len;
			end
			DIV_SINCE: begin
				div_dividend = since;
				div_divisor  = acc_q;
			end
			default: begin
				div_dividend = since;
				div_divisor  = t_len;
			end
		endcase
	end

	tsws_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// base_q holds the time floored to a whole cycle; the offset remainder is added here.
	assign start_sum = base_q + div_rem;
	assign start_fix = (start_sum > item_q.now_ms) ? start_sum - t_len : start_sum;

	assign acc_base  = first_step ? '0 : acc_q;
	assign walk_base = first_step ? '0 : walk_q;
	assign walk_nxt  = walk_base + rd_dur;
	assign found_cur = first_step ? 1'b0 : found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				entry_q[i] <= ENTRY_RESET[i];
			end
			wiu_q <= WIU_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index < REG_WINDOWS_IN_USE) begin
				entry_q[cfg_index[WIN_IDX_W-1:0]] <= cfg_data;
			end else if (cfg_index == REG_WINDOWS_IN_USE) begin
				wiu_q <= cfg_data[WIU_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			aw_q    <= '0;
			cc_q    <= '0;
		end else if (cmd.align) begin
			start_q <= start_fix;
			aw_q    <= '0;
			cc_q    <= '0;
		end else if (cmd.commit) begin
			aw_q <= idx_q;
			cc_q <= div_quo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q    <= in_data;
			changed_q <= 1'b0;
		end
		if (cmd.prefix_step) begin
			acc_q <= acc_base + (step_in_use ? rd_dur : '0);
		end
		if (div_done && (cmd.div_sel == DIV_NOW)) begin
			base_q <= item_q.now_ms - div_rem;
		end
		if (cmd.locate_step) begin
			walk_q  <= walk_nxt;
			found_q <= found_cur || (step_in_use && (div_rem < walk_nxt));
			// Until a window holds the elapsed time, each window in use is taken in turn,
			// so a walk past every duration ends on the last window in use.
			if (!found_cur && step_in_use) begin
				idx_q <= cmd.step_idx;
				lo_q  <= walk_base;
				hi_q  <= walk_nxt;
			end
		end
		if (cmd.commit && !item_q.mode) begin
			changed_q <= (idx_q != aw_q) || (div_quo != cc_q);
		end
		if (cmd.load_out) begin
			out_q.window_changed    <= changed_q;
			out_q.window_index      <= aw_q;
			out_q.bitrate_kbps      <= (n_used != '0) ? rd_rate : '0;
			out_q.cycles_elapsed    <= cc_q;
			out_q.time_in_window_ms <= active ? div_rem - lo_q : '0;
			out_q.time_to_switch_ms <= active ? hi_q - div_rem : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.mode     = item_q.mode;
	assign sts.active   = active;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

/* hw/rtl/tsws_ctrl.sv */
// Controller of the scheduler: sequences the duration walks, the divides, the realign
// and the result load. Uses tsws_pkg for the state enum and the command and status structs.
module tsws_ctrl import tsws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	state_t               state_q, state_d;
	div_sel_t             sel_q, sel_d;
	logic [WIN_IDX_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= DIV_NOW;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		step_d  = step_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PREFIX;
					step_d  = '0;
				end
			end
			ST_PREFIX: begin
				step_d = step_q + WIN_IDX_W'(1);
				if (step_q == WIN_IDX_W'(ENTRY_COUNT - 1)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (sts.mode) begin
					state_d = ST_DIV_START;
					sel_d   = DIV_NOW;
				end else if (sts.active) begin
					state_d = ST_DIV_START;
					sel_d   = DIV_SINCE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV_START: begin
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					case (sel_q)
						DIV_NOW: begin
							state_d = ST_DIV_START;
							sel_d   = DIV_OFFSET;
						end
						DIV_OFFSET: begin
							state_d = ST_ALIGN;
						end
						DIV_SINCE: begin
							state_d = ST_LOCATE;
							step_d  = '0;
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_ALIGN: begin
				if (sts.active) begin
					state_d = ST_DIV_START;
					sel_d   = DIV_SINCE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_LOCATE: begin
				step_d = step_q + WIN_IDX_W'(1);
				if (step_q == WIN_IDX_W'(ENTRY_COUNT - 1)) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.div_sel     = sel_q;
		cmd.step_idx    = step_q;
		cmd.latch       = (state_q == ST_IDLE) && in_valid;
		cmd.prefix_step = state_q == ST_PREFIX;
		cmd.div_start   = state_q == ST_DIV_START;
		cmd.align       = state_q == ST_ALIGN;
		cmd.locate_step = state_q == ST_LOCATE;
		cmd.commit      = state_q == ST_COMMIT;
		cmd.finish      = state_q == ST_FINISH;
		cmd.load_out    = (state_q == ST_FINISH) && sts.out_free;
	end

	assign in_stall = state_q != ST_IDLE;

endmodule
